@@ rtl/lkvt_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear key/value table package
// Shared constants, request modes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvt_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int KEY_WIDTH_DEFAULT   = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int MODE_W  = 3;
  localparam int POS_W   = 4;
  localparam int CAP_W   = 5;
  localparam int TOTAL_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 3'd0,
    MODE_UPDATE     = 3'd1,
    MODE_UPSERT     = 3'd2,
    MODE_ERASE      = 3'd3,
    MODE_LOOKUP     = 3'd4,
    MODE_READ_INDEX = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_MOVE,
    ST_POS,
    ST_POS_DATA,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic exec;
    logic move;
    logic pos_read;
    logic pos_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic erase_hit;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/lkvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Linear key/value table controller
// Sequences one request at a time through scan and execute or an index read,
// then result hand-off, and owns the input stall and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvt_ctrl
  import lkvt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cmd_t                   cmd,
  input  wire status_t           status
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode) inside
            MODE_READ_INDEX: state_next = ST_POS;
            MODE_INSERT, MODE_UPDATE, MODE_UPSERT, MODE_ERASE, MODE_LOOKUP:
              state_next = ST_SCAN;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.hit || status.exhausted) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = status.erase_hit ? ST_MOVE : ST_FINISH;
      end
      ST_MOVE:     state_next = ST_FINISH;
      ST_POS:      state_next = ST_POS_DATA;
      ST_POS_DATA: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != ST_IDLE);
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && in_valid;
    cmd.scan_start = (state == ST_IDLE) && in_valid;
    cmd.scan_step  = (state == ST_SCAN);
    cmd.exec       = (state == ST_EXEC);
    cmd.move       = (state == ST_MOVE);
    cmd.pos_read   = (state == ST_POS);
    cmd.pos_done   = (state == ST_POS_DATA);
    cmd.out_load   = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwrote a stalled transfer");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("accepted transfer did not start a request");

  a_result_follows_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result register loaded without valid");
`endif

endmodule

`default_nettype wire

@@ rtl/lkvt_datapath.sv @@
// ----------------------------------------------------------------------------
// Linear key/value table datapath
// Entry memory, request and result registers, live count, capacity register
// and the one-entry-per-cycle key scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvt_datapath
  import lkvt_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CAP_W-1:0]       cfg_data,
  input  wire logic [MODE_W-1:0]      mode,
  input  wire logic [KEY_WIDTH-1:0]   key,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic [POS_W-1:0]       position,
  output logic                        ok,
  output logic [KEY_WIDTH-1:0]        out_key,
  output logic [VALUE_WIDTH-1:0]      out_value,
  output logic [TOTAL_W-1:0]          entry_total,
  input  wire cmd_t                   cmd,
  output status_t                     status
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [MODE_W-1:0]      req_mode;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;
  logic [POS_W-1:0]       req_position;

  logic [CAP_W-1:0] cap;
  logic [CNT_W-1:0] cnt;

  logic [CNT_W-1:0]       sidx;
  logic                   pend;
  logic [IDX_W-1:0]       pidx;
  logic                   found;
  logic [IDX_W-1:0]       slot;
  logic [VALUE_WIDTH-1:0] fval;

  logic                   res_ok;
  logic [KEY_WIDTH-1:0]   res_key;
  logic [VALUE_WIDTH-1:0] res_val;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   sidx_lt_cnt;
  logic                   hit;
  logic                   full;
  logic                   pos_ok;
  logic [CNT_W-1:0]       cnt_last;
  logic [IDX_W-1:0]       cnt_idx;

  assign rd_key      = rd_data[ENTRY_W-1 -: KEY_WIDTH];
  assign rd_val      = rd_data[VALUE_WIDTH-1:0];
  assign sidx_lt_cnt = (sidx < cnt);
  assign hit         = pend && (rd_key == req_key);
  assign full        = (cnt == CNT_W'(DEPTH)) || (CMP_W'(cnt) >= CMP_W'(cap));
  assign pos_ok      = (CMP_W'(req_position) < CMP_W'(cnt));
  assign cnt_last    = cnt - CNT_W'(1);
  assign cnt_idx     = IDX_W'(cnt);

  assign status.hit       = hit;
  assign status.exhausted = !hit && !sidx_lt_cnt;
  assign status.erase_hit = found && (req_mode == MODE_ERASE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IDX_W'(sidx);
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = {req_key, req_value};
    if (cmd.scan_step) begin
      rd_en = sidx_lt_cnt;
    end
    if (cmd.exec) begin
      case (req_mode)
        MODE_INSERT: begin
          wr_en   = !found && !full;
          wr_addr = cnt_idx;
        end
        MODE_UPDATE: begin
          wr_en = found;
        end
        MODE_UPSERT: begin
          wr_en   = found || !full;
          wr_addr = found ? slot : cnt_idx;
        end
        MODE_ERASE: begin
          rd_en   = found;
          rd_addr = IDX_W'(cnt_last);
        end
        default: begin
        end
      endcase
    end
    if (cmd.move) begin
      wr_en   = 1'b1;
      wr_addr = slot;
      wr_data = rd_data;
    end
    if (cmd.pos_read) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(req_position);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_write) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      case (req_mode) inside
        MODE_INSERT, MODE_UPSERT: begin
          if (!found && !full) begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.move) begin
      cnt <= cnt_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      found <= 1'b0;
      sidx  <= '0;
    end else if (cmd.scan_start) begin
      pend  <= 1'b0;
      found <= 1'b0;
      sidx  <= '0;
    end else if (cmd.scan_step) begin
      pend <= sidx_lt_cnt;
      if (sidx_lt_cnt) begin
        sidx <= sidx + CNT_W'(1);
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      pidx <= IDX_W'(sidx);
      if (hit) begin
        slot <= pidx;
        fval <= rd_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode     <= mode;
      req_key      <= key;
      req_value    <= value;
      req_position <= position;
      res_ok       <= 1'b0;
      res_key      <= '0;
      res_val      <= '0;
    end
    if (cmd.exec) begin
      case (req_mode)
        MODE_INSERT: res_ok <= !found && !full;
        MODE_UPDATE: res_ok <= found;
        MODE_UPSERT: res_ok <= found || !full;
        MODE_LOOKUP: begin
          res_ok <= found;
          if (found) begin
            res_val <= fval;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.move) begin
      res_ok <= 1'b1;
    end
    if (cmd.pos_done && pos_ok) begin
      res_ok  <= 1'b1;
      res_key <= rd_key;
      res_val <= rd_val;
    end
    if (cmd.out_load) begin
      ok          <= res_ok;
      out_key     <= res_key;
      out_value   <= res_val;
      entry_total <= TOTAL_W'(cnt);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("live count above depth");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cmd.exec || cmd.move))
    else $error("entry write outside execute or move");

  a_move_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.move |=> (cnt == $past(cnt) - CNT_W'(1)))
    else $error("erase did not reduce the live count");
`endif

endmodule

`default_nettype wire

@@ rtl/linear_key_value_table.sv @@
// The key scan reads one stored entry a cycle from an entry memory with one
// read port and one write port. The table takes one request at a time: a new
// request is stalled until the result of the last one has been handed off.
// Reset clears the live count, sets capacity to 16 and empties the output;
// entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Linear key/value table
// Small key/value map kept as a packed unsorted array with a live count,
// supporting insert, update, insert-or-update, erase, lookup and read by index.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table
  import lkvt_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CAP_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [MODE_W-1:0]      mode,
  input  wire logic [KEY_WIDTH-1:0]   key,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic [POS_W-1:0]       position,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        ok,
  output logic [KEY_WIDTH-1:0]        out_key,
  output logic [VALUE_WIDTH-1:0]      out_value,
  output logic [TOTAL_W-1:0]          entry_total
);

  cmd_t    cmd;
  status_t status;

  lkvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lkvt_datapath #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .position    (position),
    .ok          (ok),
    .out_key     (out_key),
    .out_value   (out_value),
    .entry_total (entry_total),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire
